// File: rtl/core/scf_pkg.sv
// ----------------------------------------------------------------------------
// scf_pkg: shared definitions of the calibrated servo command framer
// Codes, calibration layout, queue entry format and helper functions.
// ----------------------------------------------------------------------------
package scf_pkg;

  localparam int NUM_SERVOS = 8;
  localparam int IDX_W      = 3;
  localparam int CAL_W      = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = 25;
  localparam int Q_SHIFT    = 14;
  localparam int Q_ONE      = 16384;
  // Fraction bits at or above this value round the mapped position up.
  localparam int ROUND_UP_REM = 8193;
  localparam logic [7:0] FRAME_SYNC = 8'hFF;
  localparam logic [7:0] POS_RESET  = 8'd127;
  localparam int FRAME_BEATS = 3;
  localparam int BEAT_W      = 2;
  localparam int DIV_BITS    = 4;
  localparam int DIV_CYCLES  = 4;
  localparam int DIV_CNT_W   = 2;
  localparam int QUO_W       = DIV_BITS * DIV_CYCLES;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CAL_W-1:0] NEUTRAL_RESET = 64'h7F7F_7F7F_7F7F_7F7F;
  localparam logic [CAL_W-1:0] LOW_RESET     = 64'h0000_0000_0000_0000;
  localparam logic [CAL_W-1:0] HIGH_RESET    = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    REG_NEUTRAL = 2'd0,
    REG_LOW     = 2'd1,
    REG_HIGH    = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    OP_CAL_MOVE = 2'd0,
    OP_RAW_MOVE = 2'd1,
    OP_READ     = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_SERVO = 2'd1,
    ERR_RANGE = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    JOB_ERROR = 2'd0,
    JOB_READ  = 2'd1,
    JOB_MOVE  = 2'd2
  } job_e;

  typedef enum logic [1:0] {
    F_IDLE = 2'd0,
    F_MUL  = 2'd1,
    F_PUSH = 2'd2
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_DIV  = 2'd1,
    B_EMIT = 2'd2
  } back_state_e;

  typedef enum logic [1:0] {
    FR_ZERO = 2'd0,
    FR_FULL = 2'd1,
    FR_DIV  = 2'd2
  } frac_mode_e;

  typedef struct packed {
    logic [CAL_W-1:0] neutral_pts;
    logic [CAL_W-1:0] low_pts;
    logic [CAL_W-1:0] high_pts;
  } cal_t;

  typedef struct packed {
    job_e             kind;
    err_e             err;
    logic [IDX_W-1:0] idx;
    logic [7:0]       raw;
  } job_t;

  function automatic logic [7:0] cal_byte(input logic [CAL_W-1:0] r,
                                          input logic [IDX_W-1:0] i);
    cal_byte = r[8*i +: 8];
  endfunction

endpackage

// File: rtl/core/scf_if.sv
// ----------------------------------------------------------------------------
// scf_if: command and result channels of the servo command framer
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface scf_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  servo_index;
  logic signed [15:0] target_fraction;
  logic [7:0]  target_raw;

  modport source(output valid, operation, servo_index, target_fraction, target_raw,
                 input ready);
  modport sink(input valid, operation, servo_index, target_fraction, target_raw,
               output ready);
endinterface

interface scf_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_byte;
  logic        is_frame;
  logic        last;
  logic [7:0]  position_raw;
  logic signed [15:0] position_fraction;
  logic [1:0]  error_code;

  modport source(output valid, frame_byte, is_frame, last, position_raw,
                 position_fraction, error_code, input ready);
  modport sink(input valid, frame_byte, is_frame, last, position_raw,
               position_fraction, error_code, output ready);
endinterface

// File: rtl/core/servo_calibrated_command_framer.sv
// ----------------------------------------------------------------------------
// servo_calibrated_command_framer: calibrated command framer for servos
// Maps servo targets to raw bytes, frames them for the link and reports
// stored positions back as Q1.14 fractions.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i carries one command per transaction: calibrated move, raw move or
//   read, a servo number, a Q1.14 target and a raw target. res_o returns the
//   results: three frame bytes (sync, servo, raw) for a move, or one status
//   result for a read or an error; last marks the final result of a command.
//   The APB port holds three 64-bit calibration registers (neutral, low,
//   high; one byte per servo) at byte addresses 0, 8 and 16.
//   The intake takes each command through accept, multiply and queue push
//   and takes no new command until the push. The output side pops a job,
//   runs the radix-16 divider when the fraction is neither zero nor full
//   scale, then emits one result beat per cycle while the receiver keeps
//   up. A two-entry job queue lets intake continue while results wait.
//   When the receiver stalls, the output register holds its result, the
//   queue fills and cmd_i.ready drops.
//   Reset sets all stored positions to 127 and the calibration to neutral
//   127, low 0, high 255 for every servo.
// ----------------------------------------------------------------------------
module servo_calibrated_command_framer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  scf_cmd_if.sink                         cmd_i,
  scf_res_if.source                       res_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [scf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [scf_pkg::CAL_W-1:0]       pwdata,
  output logic [scf_pkg::CAL_W-1:0]       prdata,
  output logic                            pready
);
  import scf_pkg::*;

  cal_t cal_q;
  job_t fr_job, bk_job;
  logic fr_valid, fr_ready, bk_valid, bk_ready;
  logic cfg_wr;
  reg_e cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = reg_e'(paddr[CFG_ADDR_W-1:3]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q.neutral_pts <= NEUTRAL_RESET;
      cal_q.low_pts     <= LOW_RESET;
      cal_q.high_pts    <= HIGH_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_NEUTRAL: cal_q.neutral_pts <= pwdata;
        REG_LOW:     cal_q.low_pts     <= pwdata;
        REG_HIGH:    cal_q.high_pts    <= pwdata;
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_NEUTRAL: prdata = cal_q.neutral_pts;
      REG_LOW:     prdata = cal_q.low_pts;
      REG_HIGH:    prdata = cal_q.high_pts;
      default:     prdata = '0;
    endcase
  end

  scf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .cal_i       (cal_q),
    .job_o       (fr_job),
    .job_valid_o (fr_valid),
    .job_ready_i (fr_ready)
  );

  scf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_job_i   (fr_job),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .rd_job_o   (bk_job),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready)
  );

  scf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (bk_job),
    .job_valid_i (bk_valid),
    .job_ready_o (bk_ready),
    .cal_i       (cal_q),
    .res_o       (res_o)
  );

endmodule

// File: rtl/core/scf_front.sv
// ----------------------------------------------------------------------------
// scf_front: command intake and classification
// Checks each command, maps calibrated targets to raw bytes, keeps the
// stored servo positions and pushes one job per command into the queue.
// ----------------------------------------------------------------------------
module scf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  scf_cmd_if.sink       cmd_i,
  input  scf_pkg::cal_t cal_i,
  output scf_pkg::job_t job_o,
  output logic          job_valid_o,
  input  logic          job_ready_i
);
  import scf_pkg::*;

  front_state_e state_q, state_d;

  logic [1:0]              op_q;
  logic [IDX_W-1:0]        idx_q;
  logic signed [15:0]      p_q;
  logic [7:0]              rawt_q;
  job_e                    kind_q;
  err_e                    err_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [7:0]              pos_q [NUM_SERVOS];

  logic                    accept;
  logic                    push;
  job_e                    kind_c;
  err_e                    err_c;
  logic [7:0]              neu, lo, hi;
  logic signed [8:0]       span_s;
  logic signed [11:0]      quot_s;
  logic [11:0]             cal_sum;
  logic                    round_up;
  logic [7:0]              cal_raw;
  logic [7:0]              job_raw;

  assign accept = cmd_i.valid && cmd_i.ready;
  assign push   = job_valid_o && job_ready_i;

  // Classification of the incoming command; the servo check comes first.
  always_comb begin
    kind_c = JOB_READ;
    err_c  = ERR_OK;
    unique case (op_e'(cmd_i.operation))
      OP_CAL_MOVE: kind_c = JOB_MOVE;
      OP_RAW_MOVE: kind_c = JOB_MOVE;
      default:     kind_c = JOB_READ;
    endcase
    if (cmd_i.servo_index >= 8'(NUM_SERVOS)) begin
      kind_c = JOB_ERROR;
      err_c  = ERR_SERVO;
    end else if (op_e'(cmd_i.operation) == OP_CAL_MOVE &&
                 (cmd_i.target_fraction > 16'sd16384 ||
                  cmd_i.target_fraction < -16'sd16384)) begin
      kind_c = JOB_ERROR;
      err_c  = ERR_RANGE;
    end
  end

  assign neu = cal_byte(cal_i.neutral_pts, idx_q);
  assign lo  = cal_byte(cal_i.low_pts, idx_q);
  assign hi  = cal_byte(cal_i.high_pts, idx_q);

  always_comb begin
    if (p_q[15]) begin
      span_s = $signed({1'b0, neu}) - $signed({1'b0, lo});
    end else begin
      span_s = $signed({1'b0, hi}) - $signed({1'b0, neu});
    end
    prod_d = p_q * span_s;
  end

  // Round to nearest with a bias just under one half, then clamp to a byte.
  always_comb begin
    quot_s   = {prod_q[PROD_W-1], prod_q[PROD_W-1:Q_SHIFT]};
    round_up = prod_q[Q_SHIFT-1:0] >= 14'(ROUND_UP_REM);
    cal_sum  = quot_s + {4'b0, neu} + {11'b0, round_up};
    if (cal_sum[11]) begin
      cal_raw = 8'd0;
    end else if (cal_sum[10:8] != 3'd0) begin
      cal_raw = 8'hFF;
    end else begin
      cal_raw = cal_sum[7:0];
    end
  end

  always_comb begin
    case (kind_q)
      JOB_MOVE: job_raw = (op_e'(op_q) == OP_CAL_MOVE) ? cal_raw : rawt_q;
      JOB_READ: job_raw = pos_q[idx_q];
      default:  job_raw = 8'd0;
    endcase
    job_o.kind = kind_q;
    job_o.err  = err_q;
    job_o.idx  = idx_q;
    job_o.raw  = job_raw;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE:  if (accept) state_d = F_MUL;
      F_MUL:   state_d = F_PUSH;
      F_PUSH:  if (push) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    cmd_i.ready = 1'b0;
    job_valid_o = 1'b0;
    unique case (state_q)
      F_IDLE:  cmd_i.ready = 1'b1;
      F_PUSH:  job_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      for (int i = 0; i < NUM_SERVOS; i++) begin
        pos_q[i] <= POS_RESET;
      end
    end else begin
      state_q <= state_d;
      if (push && kind_q == JOB_MOVE) begin
        pos_q[idx_q] <= job_raw;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= cmd_i.operation;
      idx_q  <= cmd_i.servo_index[IDX_W-1:0];
      p_q    <= cmd_i.target_fraction;
      rawt_q <= cmd_i.target_raw;
      kind_q <= kind_c;
      err_q  <= err_c;
    end
    if (state_q == F_MUL) begin
      prod_q <= prod_d;
    end
  end

endmodule

// File: rtl/core/scf_queue.sv
// ----------------------------------------------------------------------------
// scf_queue: short job queue between intake and output sequencing
// A small first-in first-out buffer of classified jobs.
// ----------------------------------------------------------------------------
module scf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  scf_pkg::job_t wr_job_i,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  output scf_pkg::job_t rd_job_o,
  output logic          rd_valid_o,
  input  logic          rd_ready_i
);
  import scf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_wr, do_rd;

  assign wr_ready_o = count_q != CNT_W'(QUEUE_DEPTH);
  assign rd_valid_o = count_q != '0;
  assign rd_job_o   = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

endmodule

// File: rtl/core/scf_back.sv
// ----------------------------------------------------------------------------
// scf_back: position conversion and result sequencing
// Converts the stored raw position back to Q1.14 with a radix-16 divider
// and emits one status result or the three bytes of a command frame.
// ----------------------------------------------------------------------------
module scf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  scf_pkg::job_t job_i,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  scf_pkg::cal_t cal_i,
  scf_res_if.source     res_o
);
  import scf_pkg::*;

  back_state_e state_q, state_d;

  job_t                 job_q;
  logic [7:0]           as_q;
  logic                 neg_q;
  frac_mode_e           mode_q;
  logic [7:0]           rem_q;
  logic [QUO_W-1:0]     quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [BEAT_W-1:0]    beat_q;

  logic                 out_valid_q;
  logic [7:0]           out_byte_q;
  logic                 out_isf_q;
  logic                 out_last_q;
  logic [7:0]           out_raw_q;
  logic [FRAC_W-1:0]    out_frac_q;
  logic [1:0]           out_err_q;

  logic                 pop;
  logic                 load;
  logic                 last_beat;
  logic [7:0]           neu, lo, hi;
  logic signed [8:0]    n_s, span_s;
  logic [8:0]           n_neg, span_neg;
  logic [7:0]           an_c, as_c;
  frac_mode_e           mode_c;
  logic [7:0]           rem_w;
  logic [8:0]           r2;
  logic [DIV_BITS-1:0]  bits_w;
  logic [FRAC_W-1:0]    q_round, mag, frac_c;
  logic [7:0]           beat_byte;

  assign pop  = job_valid_i && job_ready_o;
  assign load = (state_q == B_EMIT) && (!out_valid_q || res_o.ready);
  assign last_beat = (job_q.kind != JOB_MOVE) || (beat_q == BEAT_W'(FRAME_BEATS - 1));

  // Conversion setup: signed offset from neutral and the span on that side.
  assign neu = cal_byte(cal_i.neutral_pts, job_i.idx);
  assign lo  = cal_byte(cal_i.low_pts, job_i.idx);
  assign hi  = cal_byte(cal_i.high_pts, job_i.idx);

  always_comb begin
    n_s = $signed({1'b0, job_i.raw}) - $signed({1'b0, neu});
    if (job_i.raw >= neu) begin
      span_s = $signed({1'b0, hi}) - $signed({1'b0, neu});
    end else begin
      span_s = $signed({1'b0, neu}) - $signed({1'b0, lo});
    end
    n_neg    = -n_s;
    span_neg = -span_s;
    an_c = n_s[8] ? n_neg[7:0] : n_s[7:0];
    as_c = span_s[8] ? span_neg[7:0] : span_s[7:0];
    // An offset at least as large as the span saturates to full scale.
    if (n_s == 9'sd0) begin
      mode_c = FR_ZERO;
    end else if (span_s == 9'sd0 || an_c >= as_c) begin
      mode_c = FR_FULL;
    end else begin
      mode_c = FR_DIV;
    end
  end

  // Four restoring steps per cycle on the scaled offset.
  always_comb begin
    rem_w  = rem_q;
    bits_w = '0;
    r2     = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      r2 = {rem_w, 1'b0};
      if (r2 >= {1'b0, as_q}) begin
        rem_w  = 8'(r2 - {1'b0, as_q});
        bits_w = {bits_w[DIV_BITS-2:0], 1'b1};
      end else begin
        rem_w  = r2[7:0];
        bits_w = {bits_w[DIV_BITS-2:0], 1'b0};
      end
    end
  end

  // The quotient holds offset*2^16/span; drop a bit and round half up.
  always_comb begin
    q_round = ({1'b0, quo_q[QUO_W-1:1]} + 16'd1) >> 1;
    case (mode_q)
      FR_FULL: mag = 16'(Q_ONE);
      FR_DIV:  mag = q_round;
      default: mag = '0;
    endcase
    frac_c = neg_q ? (~mag + 16'd1) : mag;
  end

  always_comb begin
    case (beat_q)
      2'd0:    beat_byte = FRAME_SYNC;
      2'd1:    beat_byte = {{(8-IDX_W){1'b0}}, job_q.idx};
      default: beat_byte = job_q.raw;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (job_valid_i) begin
          if (job_i.kind != JOB_ERROR && mode_c == FR_DIV) begin
            state_d = B_DIV;
          end else begin
            state_d = B_EMIT;
          end
        end
      end
      B_DIV:   if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) state_d = B_EMIT;
      B_EMIT:  if (load && last_beat) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    job_ready_o = 1'b0;
    unique case (state_q)
      B_IDLE:  job_ready_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      beat_q      <= '0;
    end else begin
      state_q <= state_d;
      if (pop) begin
        cnt_q  <= '0;
        beat_q <= '0;
      end else begin
        if (state_q == B_DIV) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (load) begin
          beat_q <= beat_q + 1'b1;
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      job_q  <= job_i;
      as_q   <= as_c;
      neg_q  <= n_s[8] ^ span_s[8];
      mode_q <= mode_c;
      rem_q  <= an_c;
      quo_q  <= '0;
    end else if (state_q == B_DIV) begin
      rem_q <= rem_w;
      quo_q <= {quo_q[QUO_W-DIV_BITS-1:0], bits_w};
    end
    if (load) begin
      if (job_q.kind == JOB_MOVE) begin
        out_byte_q <= beat_byte;
        out_isf_q  <= 1'b1;
        out_last_q <= last_beat;
      end else begin
        out_byte_q <= 8'd0;
        out_isf_q  <= 1'b0;
        out_last_q <= 1'b1;
      end
      if (job_q.kind == JOB_ERROR) begin
        out_raw_q  <= 8'd0;
        out_frac_q <= '0;
      end else begin
        out_raw_q  <= job_q.raw;
        out_frac_q <= frac_c;
      end
      out_err_q <= job_q.err;
    end
  end

  assign res_o.valid             = out_valid_q;
  assign res_o.frame_byte        = out_byte_q;
  assign res_o.is_frame          = out_isf_q;
  assign res_o.last              = out_last_q;
  assign res_o.position_raw      = out_raw_q;
  assign res_o.position_fraction = out_frac_q;
  assign res_o.error_code        = out_err_q;

endmodule

// File: rtl/core/scf_checker.sv
// ----------------------------------------------------------------------------
// scf_checker: port-level checks of the servo command framer
// Result stream consistency, observed on the top-level result channel.
// ----------------------------------------------------------------------------
module scf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               res_valid_i,
  input logic               res_ready_i,
  input logic [7:0]         frame_byte_i,
  input logic               is_frame_i,
  input logic               last_i,
  input logic [7:0]         position_raw_i,
  input logic signed [15:0] position_fraction_i,
  input logic [1:0]         error_code_i
);
  import scf_pkg::*;

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(frame_byte_i) &&
      $stable(is_frame_i) && $stable(last_i) && $stable(position_raw_i) &&
      $stable(position_fraction_i) && $stable(error_code_i))
    else $error("result changed while stalled");

  a_frame_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && is_frame_i |-> error_code_i == 2'(ERR_OK))
    else $error("frame byte carries an error code");

  a_status_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !is_frame_i |-> last_i && frame_byte_i == 8'd0)
    else $error("status result is not a single final result");

  // The closing frame byte is the position that was stored.
  a_frame_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && is_frame_i && last_i |-> frame_byte_i == position_raw_i)
    else $error("final frame byte differs from stored position");

  // Frame bytes follow one another without a gap.
  a_frame_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && is_frame_i && !last_i |=> res_valid_i && is_frame_i)
    else $error("frame interrupted");

endmodule

bind servo_calibrated_command_framer scf_checker u_scf_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .res_valid_i         (res_o.valid),
  .res_ready_i         (res_o.ready),
  .frame_byte_i        (res_o.frame_byte),
  .is_frame_i          (res_o.is_frame),
  .last_i              (res_o.last),
  .position_raw_i      (res_o.position_raw),
  .position_fraction_i (res_o.position_fraction),
  .error_code_i        (res_o.error_code)
);

// File: bench/scf_checker.sv
// ----------------------------------------------------------------------------
// scf_scoreboard: result predictor and scoreboard for the servo command framer
// Watches the command, result and APB channels, keeps its own copy of the
// calibration and stored positions, predicts the results of every accepted
// command and compares each delivered result with the oldest prediction.
// ----------------------------------------------------------------------------
module scf_scoreboard (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  scf_cmd_if                             cmd_i,
  scf_res_if                             res_i,
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic [scf_pkg::CFG_ADDR_W-1:0] paddr_i,
  input  logic [scf_pkg::CAL_W-1:0]      pwdata_i,
  input  logic                           pready_i,
  output int                             fail_cnt_o,
  output int                             pending_o
);
  import scf_pkg::*;

  localparam longint MAP_SCALE = 100000;
  localparam longint MAP_BIAS  = 49999;
  localparam longint MAP_DEN   = longint'(Q_ONE) * MAP_SCALE;

  typedef struct packed {
    logic [7:0]         frame_byte;
    logic               is_frame;
    logic               last;
    logic [7:0]         position_raw;
    logic signed [15:0] position_fraction;
    logic [1:0]         error_code;
  } link_result_t;

  logic [CAL_W-1:0] neutral_q;
  logic [CAL_W-1:0] low_q;
  logic [CAL_W-1:0] high_q;
  logic [7:0]       stored_pos [NUM_SERVOS];
  link_result_t     expected_q [$];
  link_result_t     got;
  link_result_t     want;
  int               mismatches;

  function automatic int cal_field(input logic [CAL_W-1:0] r, input logic [IDX_W-1:0] s);
    return int'(r[8*s +: 8]);
  endfunction

  // Target to raw byte: neutral + p*span/16384 + 0.49999, truncated, clamped.
  function automatic logic [7:0] map_target(input logic [IDX_W-1:0] s, input int p);
    int     neu;
    int     span;
    longint x;
    longint r;
    neu  = cal_field(neutral_q, s);
    span = (p < 0) ? neu - cal_field(low_q, s) : cal_field(high_q, s) - neu;
    x = longint'(p) * span * MAP_SCALE + longint'(neu) * MAP_DEN + MAP_BIAS * Q_ONE;
    if (x < 0) return 8'd0;
    r = x / MAP_DEN;
    return (r > 255) ? 8'd255 : 8'(r);
  endfunction

  // Raw byte back to Q1.14, rounded half away from zero, clamped to +-1.0.
  function automatic logic signed [15:0] raw_to_q14(input logic [IDX_W-1:0] s, input int raw);
    int     neu;
    int     span;
    int     n;
    longint num;
    longint den;
    longint q;
    bit     neg;
    neu  = cal_field(neutral_q, s);
    span = (raw >= neu) ? cal_field(high_q, s) - neu : neu - cal_field(low_q, s);
    n    = raw - neu;
    if (n == 0) return 16'sd0;
    if (span == 0) return (n > 0) ? 16'sd16384 : -16'sd16384;
    neg = (n < 0) != (span < 0);
    num = longint'((n < 0) ? -n : n) * Q_ONE;
    den = longint'((span < 0) ? -span : span);
    q   = (2 * num + den) / (2 * den);
    if (q > Q_ONE) q = Q_ONE;
    return neg ? 16'(-q) : 16'(q);
  endfunction

  task automatic predict_command(input logic [1:0] op, input logic [7:0] s,
                                 input logic signed [15:0] tf, input logic [7:0] rt);
    link_result_t r;
    int           p;
    logic [7:0]   raw;
    logic signed [15:0] frac;
    r      = '0;
    r.last = 1'b1;
    p      = tf;
    if (s >= NUM_SERVOS) begin
      r.error_code = ERR_SERVO;
      expected_q.push_back(r);
      return;
    end
    if (op == OP_CAL_MOVE) begin
      if (p > Q_ONE || p < -Q_ONE) begin
        r.error_code = ERR_RANGE;
        expected_q.push_back(r);
        return;
      end
      raw = map_target(s[IDX_W-1:0], p);
    end else if (op == OP_RAW_MOVE) begin
      raw = rt;
    end else begin
      // Reads, and the unused operation code, report the stored position.
      raw = stored_pos[s[IDX_W-1:0]];
      r.error_code        = ERR_OK;
      r.position_raw      = raw;
      r.position_fraction = raw_to_q14(s[IDX_W-1:0], int'(raw));
      expected_q.push_back(r);
      return;
    end
    stored_pos[s[IDX_W-1:0]] = raw;
    frac = raw_to_q14(s[IDX_W-1:0], int'(raw));
    for (int k = 0; k < FRAME_BEATS; k++) begin
      r.is_frame          = 1'b1;
      r.last              = (k == FRAME_BEATS - 1);
      r.position_raw      = raw;
      r.position_fraction = frac;
      r.error_code        = ERR_OK;
      r.frame_byte        = (k == 0) ? FRAME_SYNC : (k == 1) ? s : raw;
      expected_q.push_back(r);
    end
  endtask

  task automatic flag_field(input string field, input logic signed [31:0] exp_val,
                            input logic signed [31:0] act_val);
    mismatches++;
    $display("%0t: %s expected %0d actual %0d", $time, field, exp_val, act_val);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neutral_q = NEUTRAL_RESET;
      low_q     = LOW_RESET;
      high_q    = HIGH_RESET;
      for (int i = 0; i < NUM_SERVOS; i++) stored_pos[i] = POS_RESET;
      expected_q.delete();
      mismatches = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        got.frame_byte        = res_i.frame_byte;
        got.is_frame          = res_i.is_frame;
        got.last              = res_i.last;
        got.position_raw      = res_i.position_raw;
        got.position_fraction = res_i.position_fraction;
        got.error_code        = res_i.error_code;
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: result expected none, actual frame_byte %0d last %0b error %0d",
                   $time, got.frame_byte, got.last, got.error_code);
        end else begin
          want = expected_q.pop_front();
          if (got.frame_byte !== want.frame_byte)
            flag_field("frame_byte", want.frame_byte, got.frame_byte);
          if (got.is_frame !== want.is_frame)
            flag_field("is_frame", want.is_frame, got.is_frame);
          if (got.last !== want.last)
            flag_field("last", want.last, got.last);
          if (got.position_raw !== want.position_raw)
            flag_field("position_raw", want.position_raw, got.position_raw);
          if (got.position_fraction !== want.position_fraction)
            flag_field("position_fraction", want.position_fraction, got.position_fraction);
          if (got.error_code !== want.error_code)
            flag_field("error_code", want.error_code, got.error_code);
        end
      end
      if (cmd_i.valid && cmd_i.ready)
        predict_command(cmd_i.operation, cmd_i.servo_index, cmd_i.target_fraction,
                        cmd_i.target_raw);
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_e'(paddr_i[CFG_ADDR_W-1:3]))
          REG_NEUTRAL: neutral_q = pwdata_i;
          REG_LOW:     low_q     = pwdata_i;
          REG_HIGH:    high_q    = pwdata_i;
          default: ;
        endcase
      end
      fail_cnt_o <= mismatches;
      pending_o  <= expected_q.size();
    end
  end

endmodule

// File: bench/tb_servo_calibrated_command_framer.sv
// ----------------------------------------------------------------------------
// tb_servo_calibrated_command_framer: testbench of the servo command framer
// Drives directed and random commands under several calibrations loaded over
// APB, with random idle bursts on both channels and one long receiver stall.
// A scoreboard module beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_servo_calibrated_command_framer;
  import scf_pkg::*;

  localparam logic [1:0] OP_SPARE   = 2'd3;
  localparam int         PHASE_CMDS = 14;
  localparam int         LONG_HOLD  = 120;
  localparam int         TAIL_WAIT  = 20;

  typedef enum int {
    CAL_FORWARD,
    CAL_SCATTER,
    CAL_REVERSED,
    CAL_FLAT,
    CAL_EDGE_LOW,
    CAL_EDGE_HIGH
  } cal_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CAL_W-1:0]      pwdata;
  logic [CAL_W-1:0]      prdata;
  logic                  pready;
  int                    fail_cnt;
  int                    pending;
  bit                    idle_on;
  bit                    hold_req;

  scf_cmd_if cmd_if ();
  scf_res_if res_if ();

  servo_calibrated_command_framer u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  scf_scoreboard u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_if),
    .res_i      (res_if),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .pready_i   (pready),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

  // Result receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    res_if.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Called at a clock edge; returns at the edge where the transaction completes.
  task automatic send_command(input logic [1:0] op, input logic [7:0] s,
                              input logic signed [15:0] tf, input logic [7:0] rt);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid           <= 1'b1;
    cmd_if.operation       <= op;
    cmd_if.servo_index     <= s;
    cmd_if.target_fraction <= tf;
    cmd_if.target_raw      <= rt;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_e r, input logic [CAL_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(8 * int'(r));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_calibration(input cal_mode_e mode);
    logic [CAL_W-1:0] neu;
    logic [CAL_W-1:0] lo;
    logic [CAL_W-1:0] hi;
    logic [7:0]       n;
    for (int k = 0; k < NUM_SERVOS; k++) begin
      n = 8'($urandom);
      case (mode)
        CAL_FORWARD: begin
          n = 8'($urandom_range(32, 223));
          lo[8*k +: 8] = n - 8'($urandom_range(0, 32));
          hi[8*k +: 8] = n + 8'($urandom_range(0, 32));
        end
        CAL_SCATTER: begin
          lo[8*k +: 8] = 8'($urandom);
          hi[8*k +: 8] = 8'($urandom);
        end
        CAL_REVERSED: begin
          n = 8'($urandom_range(64, 191));
          lo[8*k +: 8] = n + 8'($urandom_range(1, 64));
          hi[8*k +: 8] = n - 8'($urandom_range(1, 64));
        end
        CAL_FLAT: begin
          // Zero span on one side or on both.
          case ($urandom_range(0, 2))
            0: begin lo[8*k +: 8] = n;           hi[8*k +: 8] = n;           end
            1: begin lo[8*k +: 8] = n;           hi[8*k +: 8] = 8'($urandom); end
            default: begin lo[8*k +: 8] = 8'($urandom); hi[8*k +: 8] = n;    end
          endcase
        end
        CAL_EDGE_LOW: begin
          n = 8'h00;
          lo[8*k +: 8] = 8'hFF;
          hi[8*k +: 8] = 8'hFF;
        end
        default: begin
          n = 8'hFF;
          lo[8*k +: 8] = 8'h00;
          hi[8*k +: 8] = 8'h00;
        end
      endcase
      neu[8*k +: 8] = n;
    end
    wait_drained();
    apb_write(REG_NEUTRAL, neu);
    apb_write(REG_LOW, lo);
    apb_write(REG_HIGH, hi);
  endtask

  // Mostly well-formed commands, with some bad servos and bad targets.
  task automatic send_random(input int count, input bit with_hold);
    logic [1:0]         op;
    logic [7:0]         s;
    logic signed [15:0] tf;
    int                 pick;
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == 4) hold_req = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 45)      op = OP_CAL_MOVE;
      else if (pick < 65) op = OP_RAW_MOVE;
      else if (pick < 95) op = OP_READ;
      else                op = OP_SPARE;
      s = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(NUM_SERVOS, 255))
                                      : 8'($urandom_range(0, NUM_SERVOS - 1));
      pick = $urandom_range(0, 99);
      if (pick < 10)      tf = 16'(Q_ONE * ($urandom_range(0, 2) - 1));
      else if (pick < 85) tf = 16'($urandom_range(0, 2 * Q_ONE) - Q_ONE);
      else                tf = 16'($urandom);
      send_command(op, s, tf, 8'($urandom));
    end
  endtask

  initial begin
    rst_ni                 = 1'b0;
    cmd_if.valid           = 1'b0;
    cmd_if.operation       = OP_CAL_MOVE;
    cmd_if.servo_index     = 8'd0;
    cmd_if.target_fraction = 16'sd0;
    cmd_if.target_raw      = 8'd0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    idle_on                = 1'b1;
    hold_req               = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed commands under the reset calibration.
    send_command(OP_CAL_MOVE, 8'd0,   16'sd16384,  8'd0);
    send_command(OP_CAL_MOVE, 8'd7,  -16'sd16384,  8'd0);
    send_command(OP_CAL_MOVE, 8'd1,   16'sd0,      8'd0);
    send_command(OP_CAL_MOVE, 8'd2,   16'sd1,      8'd0);
    send_command(OP_CAL_MOVE, 8'd3,  -16'sd1,      8'd0);
    send_command(OP_CAL_MOVE, 8'd4,   16'sd8192,   8'd0);
    send_command(OP_CAL_MOVE, 8'd5,  -16'sd8192,   8'd0);
    send_command(OP_CAL_MOVE, 8'd0,   16'sd16385,  8'd0);
    send_command(OP_CAL_MOVE, 8'd0,  -16'sd16385,  8'd0);
    send_command(OP_CAL_MOVE, 8'd1,   16'sd32767,  8'hFF);
    send_command(OP_CAL_MOVE, 8'd1,  -16'sd32768,  8'd0);
    send_command(OP_CAL_MOVE, 8'd8,   16'sd0,      8'd0);
    // A bad servo wins over a bad target.
    send_command(OP_CAL_MOVE, 8'd255, 16'sd32767,  8'd0);
    send_command(OP_RAW_MOVE, 8'd255, 16'sd0,      8'hFF);
    send_command(OP_READ,     8'd200, 16'sd0,      8'd0);
    send_command(OP_RAW_MOVE, 8'd6,  -16'sd32768,  8'd0);
    send_command(OP_RAW_MOVE, 8'd6,   16'sd0,      8'hFF);
    send_command(OP_RAW_MOVE, 8'd2,   16'sd0,      8'd200);
    send_command(OP_READ,     8'd2,   16'sd0,      8'd0);
    send_command(OP_READ,     8'd6,   16'sd0,      8'd0);
    send_command(OP_READ,     8'd7,   16'sd0,      8'd0);
    send_command(OP_SPARE,    8'd0,   16'sd0,      8'd0);
    send_command(OP_READ,     8'd3,   16'sd0,      8'd0);
    send_command(OP_RAW_MOVE, 8'd4,   16'sd32767,  8'd127);
    send_command(OP_READ,     8'd4,   16'sd0,      8'd0);
    cmd_if.valid <= 1'b0;

    load_calibration(CAL_FORWARD);
    send_random(PHASE_CMDS, 1'b1);
    cmd_if.valid <= 1'b0;
    load_calibration(CAL_SCATTER);
    send_random(PHASE_CMDS, 1'b0);
    cmd_if.valid <= 1'b0;
    load_calibration(CAL_REVERSED);
    send_random(PHASE_CMDS, 1'b0);
    cmd_if.valid <= 1'b0;
    load_calibration(CAL_FLAT);
    send_random(PHASE_CMDS, 1'b0);
    cmd_if.valid <= 1'b0;
    load_calibration(CAL_EDGE_LOW);
    send_random(PHASE_CMDS, 1'b0);
    cmd_if.valid <= 1'b0;
    load_calibration(CAL_EDGE_HIGH);
    send_random(PHASE_CMDS, 1'b0);
    cmd_if.valid <= 1'b0;
    load_calibration(CAL_SCATTER);
    idle_on = 1'b0;
    send_random(PHASE_CMDS, 1'b0);
    cmd_if.valid <= 1'b0;

    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
